// File: rtl/mbe_pkg.sv
// Shared constants, register codes and controller/datapath handshake types.
package mbe_pkg;

    // Default geometry
    localparam int DEF_COORD_WIDTH = 10;
    localparam int DEF_FRAC_BITS   = 28;
    localparam int DEF_ITER_WIDTH  = 10;

    // Fixed field widths
    localparam int ORIGIN_W  = 10;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam int RST_MAX_ITER   = 100;
    localparam int RST_ORIGIN_X   = 160;
    localparam int RST_ORIGIN_Y   = 100;
    localparam int RST_PIXEL_STEP = 3355443;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER   = 2'd0,
        CFG_ORIGIN_X   = 2'd1,
        CFG_ORIGIN_Y   = 2'd2,
        CFG_PIXEL_STEP = 2'd3
    } t_cfg_idx;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic init;
        logic mul;
        logic upd;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_mbe_cmd;

    // Datapath to controller
    typedef struct packed {
        logic max_zero;
        logic escape;
        logic last_iter;
        logic out_free;
    } t_mbe_sts;

endpackage

// File: rtl/mbe_if.sv
// Channel interfaces: pixel input, result output and configuration write.
interface mbe_pix_if #(
    parameter int COORD_WIDTH = mbe_pkg::DEF_COORD_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;

    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mbe_res_if #(
    parameter int ITER_WIDTH = mbe_pkg::DEF_ITER_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic [mbe_pkg::COLOR_W-1:0] color;
    logic [ITER_WIDTH-1:0]       iteration_count;
    logic                        escaped;

    modport source (output valid, color, iteration_count, escaped, input ready);
    modport sink   (input valid, color, iteration_count, escaped, output ready);
endinterface

interface mbe_cfg_if #(
    parameter int DATA_W = mbe_pkg::DEF_FRAC_BITS + 1
);
    logic                          valid;
    logic                          ready;
    logic [mbe_pkg::CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/mbe_cfg_regs.sv
// Configuration register bank: iteration limit, origin and pixel step.
module mbe_cfg_regs #(
    parameter int FRAC_BITS  = mbe_pkg::DEF_FRAC_BITS,
    parameter int ITER_WIDTH = mbe_pkg::DEF_ITER_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mbe_cfg_if.sink                        i_cfg,
    output logic [ITER_WIDTH-1:0]          o_max_iter,
    output logic [mbe_pkg::ORIGIN_W-1:0]   o_origin_x,
    output logic [mbe_pkg::ORIGIN_W-1:0]   o_origin_y,
    output logic [FRAC_BITS:0]             o_pixel_step
);
    import mbe_pkg::*;

    localparam int STEP_W = FRAC_BITS + 1;

    logic [ITER_WIDTH-1:0] r_max_iter;
    logic [ORIGIN_W-1:0]   r_origin_x;
    logic [ORIGIN_W-1:0]   r_origin_y;
    logic [STEP_W-1:0]     r_pixel_step;

    // Always able to take a write
    assign i_cfg.ready = 1'b1;

    // Decode the index and update the addressed register on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= ITER_WIDTH'(RST_MAX_ITER);
            r_origin_x   <= ORIGIN_W'(RST_ORIGIN_X);
            r_origin_y   <= ORIGIN_W'(RST_ORIGIN_Y);
            r_pixel_step <= STEP_W'(RST_PIXEL_STEP);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_MAX_ITER:   r_max_iter   <= i_cfg.data[ITER_WIDTH-1:0];
                CFG_ORIGIN_X:   r_origin_x   <= i_cfg.data[ORIGIN_W-1:0];
                CFG_ORIGIN_Y:   r_origin_y   <= i_cfg.data[ORIGIN_W-1:0];
                CFG_PIXEL_STEP: r_pixel_step <= i_cfg.data[STEP_W-1:0];
            endcase
        end
    end

    assign o_max_iter   = r_max_iter;
    assign o_origin_x   = r_origin_x;
    assign o_origin_y   = r_origin_y;
    assign o_pixel_step = r_pixel_step;

endmodule

// File: rtl/mbe_ctrl.sv
// Sequencer: accept, iterate (multiply then update), divide, deliver.
module mbe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mbe_pkg::t_mbe_sts i_sts,
    output mbe_pkg::t_mbe_cmd o_cmd
);
    import mbe_pkg::*;

    localparam int BIT_W = $clog2(COLOR_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MUL,
        S_UPD,
        S_DIV_LD,
        S_DIV,
        S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    // Next state and quotient bit counter
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_INIT;
            end
            S_INIT: begin
                n_state = i_sts.max_zero ? S_OUT : S_MUL;
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_sts.escape || i_sts.last_iter) n_state = S_DIV_LD;
                else                                 n_state = S_MUL;
            end
            S_DIV_LD: begin
                n_state = S_DIV;
                n_bit   = BIT_W'(COLOR_W - 1);
            end
            S_DIV: begin
                if (r_bit == '0) n_state = S_OUT;
                else             n_bit   = r_bit - BIT_W'(1);
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    // Decode datapath commands from the state
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.init     = (r_state == S_INIT);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.div_load = (r_state == S_DIV_LD);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_OUT) && i_sts.out_free;
    end

    a_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_INIT)
        else $error("accepted pixel did not start initialization");

    a_escape_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && i_sts.escape) |=> r_state == S_DIV_LD)
        else $error("escape did not end the iteration loop");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == '0) |=> r_state == S_OUT)
        else $error("divider did not finish after the last quotient bit");

endmodule

// File: rtl/mbe_dp.sv
// Datapath: point mapping, z iteration, color divider and output register.
module mbe_dp #(
    parameter int COORD_WIDTH = mbe_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = mbe_pkg::DEF_FRAC_BITS,
    parameter int ITER_WIDTH  = mbe_pkg::DEF_ITER_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mbe_pkg::t_mbe_cmd            i_cmd,
    output mbe_pkg::t_mbe_sts            o_sts,
    input  logic [ITER_WIDTH-1:0]        i_max_iter,
    input  logic [mbe_pkg::ORIGIN_W-1:0] i_origin_x,
    input  logic [mbe_pkg::ORIGIN_W-1:0] i_origin_y,
    input  logic [FRAC_BITS:0]           i_pixel_step,
    input  logic [COORD_WIDTH-1:0]       i_pixel_x,
    input  logic [COORD_WIDTH-1:0]       i_pixel_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mbe_pkg::COLOR_W-1:0]  o_color,
    output logic [ITER_WIDTH-1:0]        o_iteration_count,
    output logic                         o_escaped
);
    import mbe_pkg::*;

    localparam int VAL_W  = FRAC_BITS + 4;
    localparam int STEP_W = FRAC_BITS + 1;
    localparam int DIFF_W = ((COORD_WIDTH > ORIGIN_W) ? COORD_WIDTH : ORIGIN_W) + 1;
    localparam int PROD_W = DIFF_W + STEP_W + 1;
    localparam int SQ_W   = 2 * VAL_W;
    localparam int WIDE_W = SQ_W + 1;
    localparam int NUM_W  = ITER_WIDTH + COLOR_W;
    localparam int DSR_W  = ITER_WIDTH + COLOR_W - 1;
    localparam logic [SQ_W-1:0] LIMIT4 = SQ_W'(1) << (2 * FRAC_BITS + 2);

    // Saturate a wide signed value to the iterate range
    function automatic logic signed [VAL_W-1:0] sat(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-VAL_W:0] hi;
        hi = v[WIDE_W-1:VAL_W-1];
        if (&hi || ~|hi)    sat = v[VAL_W-1:0];
        else if (hi[WIDE_W-VAL_W]) sat = {1'b1, {(VAL_W-1){1'b0}}};
        else                sat = {1'b0, {(VAL_W-1){1'b1}}};
    endfunction

    logic signed [DIFF_W-1:0] diff_x, diff_y;
    logic signed [STEP_W:0]   step_s;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic signed [PROD_W-1:0] r_pcr, r_pci;
    logic signed [VAL_W-1:0]  r_cr, r_ci, r_zr, r_zi;
    logic signed [SQ_W-1:0]   sq_r, sq_i, sq_ri;
    logic signed [SQ_W-1:0]   r_rr, r_ii, r_ri;
    logic [SQ_W-1:0]          mag;
    logic signed [SQ_W-1:0]   re_diff;
    logic signed [WIDE_W-1:0] nr_w, ni_w;
    logic                     escape;
    logic [ITER_WIDTH-1:0]    r_count;
    logic                     r_esc;
    logic [ITER_WIDTH:0]      count_inc;
    logic [NUM_W-1:0]         r_rem;
    logic [DSR_W-1:0]         r_dsr;
    logic [COLOR_W-1:0]       r_quot;
    logic                     fits;
    logic                     r_out_valid;
    logic [COLOR_W-1:0]       r_out_color;
    logic [ITER_WIDTH-1:0]    r_out_cnt;
    logic                     r_out_esc;

    // Map pixel to the unsaturated point
    assign diff_x = $signed({{(DIFF_W-COORD_WIDTH){1'b0}}, i_pixel_x})
                  - $signed({{(DIFF_W-ORIGIN_W){1'b0}}, i_origin_x});
    assign diff_y = $signed({{(DIFF_W-COORD_WIDTH){1'b0}}, i_pixel_y})
                  - $signed({{(DIFF_W-ORIGIN_W){1'b0}}, i_origin_y});
    assign step_s = $signed({1'b0, i_pixel_step});
    assign prod_x = diff_x * step_s;
    assign prod_y = diff_y * step_s;

    // Squares and cross product of z
    assign sq_r  = r_zr * r_zr;
    assign sq_i  = r_zi * r_zi;
    assign sq_ri = r_zr * r_zi;

    // Escape test and next z from the registered products
    assign mag     = $unsigned(r_rr) + $unsigned(r_ii);
    assign escape  = mag > LIMIT4;
    assign re_diff = r_rr - r_ii;
    assign nr_w    = WIDE_W'(re_diff >>> FRAC_BITS) + WIDE_W'(r_cr);
    assign ni_w    = WIDE_W'(r_ri >>> (FRAC_BITS - 1)) + WIDE_W'(r_ci);

    assign count_inc = {1'b0, r_count} + (ITER_WIDTH + 1)'(1);

    // One restoring step of the color division
    assign fits = r_rem >= {1'b0, r_dsr};

    // Point, iterate and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pcr <= prod_x;
            r_pci <= prod_y;
        end
        if (i_cmd.init) begin
            r_cr    <= sat(WIDE_W'(r_pcr));
            r_ci    <= sat(WIDE_W'(r_pci));
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
            r_esc   <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_rr <= sq_r;
            r_ii <= sq_i;
            r_ri <= sq_ri;
        end
        if (i_cmd.upd) begin
            if (escape) begin
                r_esc <= 1'b1;
            end else begin
                r_zr    <= sat(nr_w);
                r_zi    <= sat(ni_w);
                r_count <= count_inc[ITER_WIDTH-1:0];
            end
        end
        if (i_cmd.div_load) begin
            r_rem  <= {r_count, {COLOR_W{1'b0}}} - NUM_W'(r_count);
            r_dsr  <= {i_max_iter, {(COLOR_W-1){1'b0}}};
            r_quot <= '0;
        end
        if (i_cmd.div_step) begin
            if (fits) r_rem <= r_rem - {1'b0, r_dsr};
            r_quot <= {r_quot[COLOR_W-2:0], fits};
            r_dsr  <= r_dsr >> 1;
        end
    end

    // Output register: load on finish, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_color <= o_sts.max_zero ? '0 : r_quot;
            r_out_cnt   <= r_count;
            r_out_esc   <= r_esc;
        end
    end

    // Status back to the sequencer
    always_comb begin
        o_sts           = '0;
        o_sts.max_zero  = ~|i_max_iter;
        o_sts.escape    = escape;
        o_sts.last_iter = count_inc >= {1'b0, i_max_iter};
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_color           = r_out_color;
    assign o_iteration_count = r_out_cnt;
    assign o_escaped         = r_out_esc;

    a_esc_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_esc) |-> r_out_cnt < i_max_iter)
        else $error("escaped result reports a count at the limit");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_color)
                                           && $stable(r_out_cnt) && $stable(r_out_esc)))
        else $error("stalled result changed before transfer");

endmodule

// File: rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time pixel evaluator.
//
// Channels: i_pix carries one pixel (pixel_x, pixel_y) per transfer; o_res
// returns one result (color, iteration_count, escaped) per pixel, in order.
// i_cfg writes max_iterations, origin_x, origin_y and pixel_step by index
// 0..3; write only while no pixel is in flight.
// The pixel is first mapped to its point. Each iteration then does a square/cross
// multiply, then an escape test and update; a point that escapes takes one more
// such pair than its count shows. A bit-serial division then scales the count
// to the color, and the result is handed off to the output register. One pixel
// is worked on at a time; i_pix.ready is high when the sequencer is idle, so the
// next pixel can transfer in the same cycle as the result is presented.
// The result sits in an output register, so the next pixel is taken while
// a result waits. If the receiver stalls, the finished pixel waits in the
// sequencer until the register frees, and no new pixel is taken meanwhile.
// Reset (synchronous, active low) restores the register defaults, returns
// the sequencer to idle and drops any pending result.
module mandelbrot_escape_time #(
    parameter int COORD_WIDTH = mbe_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = mbe_pkg::DEF_FRAC_BITS,
    parameter int ITER_WIDTH  = mbe_pkg::DEF_ITER_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbe_cfg_if.sink    i_cfg,
    mbe_pix_if.sink    i_pix,
    mbe_res_if.source  o_res
);
    import mbe_pkg::*;

    logic [ITER_WIDTH-1:0] max_iter;
    logic [ORIGIN_W-1:0]   origin_x;
    logic [ORIGIN_W-1:0]   origin_y;
    logic [FRAC_BITS:0]    pixel_step;
    t_mbe_cmd              cmd;
    t_mbe_sts              sts;

    // Configuration registers
    mbe_cfg_regs #(
        .FRAC_BITS  (FRAC_BITS),
        .ITER_WIDTH (ITER_WIDTH)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_max_iter   (max_iter),
        .o_origin_x   (origin_x),
        .o_origin_y   (origin_y),
        .o_pixel_step (pixel_step)
    );

    // Sequencer
    mbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Arithmetic and output register
    mbe_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .ITER_WIDTH  (ITER_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_max_iter        (max_iter),
        .i_origin_x        (origin_x),
        .i_origin_y        (origin_y),
        .i_pixel_step      (pixel_step),
        .i_pixel_x         (i_pix.pixel_x),
        .i_pixel_y         (i_pix.pixel_y),
        .o_out_valid       (o_res.valid),
        .i_out_ready       (o_res.ready),
        .o_color           (o_res.color),
        .o_iteration_count (o_res.iteration_count),
        .o_escaped         (o_res.escaped)
    );

endmodule

// File: dv/tb_mandelbrot_escape_time.sv
// Self-checking testbench for the Mandelbrot escape-time pixel evaluator.
module tb_mandelbrot_escape_time;
    timeunit 1ns;
    timeprecision 1ps;

    import mbe_pkg::*;

    localparam int FRAC       = DEF_FRAC_BITS;
    localparam int STEP_W     = DEF_FRAC_BITS + 1;
    localparam int STEP_ONE   = 1 << FRAC;
    localparam int VIEW_LO    = STEP_ONE / 1024;
    localparam int VIEW_HI    = STEP_ONE / 100;
    localparam int NUM_PHASES = 11;
    localparam int PHASE_LEN  = 122;
    localparam int SLOW_LEN   = 24;
    localparam int WATCHDOG   = 20000;
    localparam int TAIL       = 2200;

    localparam longint Q_MAX  = (64'sd1 <<< (FRAC + 3)) - 1;
    localparam longint Q_MIN  = -Q_MAX - 1;
    localparam logic [64:0] ESCAPE_RADIUS2 = 65'd4 << (2 * FRAC);

    typedef struct packed {
        logic [COLOR_W-1:0]        color;
        logic [DEF_ITER_WIDTH-1:0] count;
        logic                      escaped;
    } t_escape_result;

    typedef struct {
        bit                        is_cfg;
        t_cfg_idx                  idx;
        logic [STEP_W-1:0]         data;
        logic [DEF_COORD_WIDTH-1:0] px;
        logic [DEF_COORD_WIDTH-1:0] py;
        bit                        typed;
        t_escape_result            want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbe_cfg_if #(.DATA_W(STEP_W))               cfg_ch ();
    mbe_pix_if #(.COORD_WIDTH(DEF_COORD_WIDTH)) pix_ch ();
    mbe_res_if #(.ITER_WIDTH(DEF_ITER_WIDTH))   res_ch ();

    mandelbrot_escape_time i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    // Register copies that the predictor works from
    logic [DEF_ITER_WIDTH-1:0] cur_max_iter;
    logic [ORIGIN_W-1:0]       cur_origin_x;
    logic [ORIGIN_W-1:0]       cur_origin_y;
    logic [STEP_W-1:0]         cur_step;

    t_escape_result predicted_escapes[$];
    t_escape_result oldest_escape;
    t_stim_row      directed[$];
    int             mismatches = 0;
    int             send_idle  = 0;
    int             recv_stall = 0;
    int             quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    function automatic longint q_clamp(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Iterate z = z*z + c in Q4.28 and scale the count to a color
    function automatic t_escape_result escape_time(input logic [DEF_COORD_WIDTH-1:0] px,
                                                   input logic [DEF_COORD_WIDTH-1:0] py);
        longint         cr, ci, zr, zi, rr, ii, ri;
        logic [64:0]    mag2;
        int unsigned    count;
        t_escape_result r;
        cr = q_clamp((longint'(px) - longint'(cur_origin_x)) * longint'(cur_step));
        ci = q_clamp((longint'(py) - longint'(cur_origin_y)) * longint'(cur_step));
        zr = 0;
        zi = 0;
        count = 0;
        r = '0;
        while (count < cur_max_iter) begin
            rr = zr * zr;
            ii = zi * zi;
            mag2 = {1'b0, rr} + {1'b0, ii};
            if (mag2 > ESCAPE_RADIUS2) begin
                r.escaped = 1'b1;
                break;
            end
            // Both components come from the old z
            ri = zr * zi;
            zr = q_clamp(((rr - ii) >>> FRAC) + cr);
            zi = q_clamp((ri >>> (FRAC - 1)) + ci);
            count++;
        end
        r.count = DEF_ITER_WIDTH'(count);
        if (cur_max_iter != '0) r.color = COLOR_W'((count * 255) / cur_max_iter);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    // Check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (predicted_escapes.size() == 0) begin
                report_mismatch("result with nothing pending", res_ch.iteration_count, -1);
            end else begin
                oldest_escape = predicted_escapes.pop_front();
                if (res_ch.color !== oldest_escape.color)
                    report_mismatch("color", res_ch.color, oldest_escape.color);
                if (res_ch.iteration_count !== oldest_escape.count)
                    report_mismatch("iteration_count", res_ch.iteration_count,
                                    oldest_escape.count);
                if (res_ch.escaped !== oldest_escape.escaped)
                    report_mismatch("escaped", res_ch.escaped, oldest_escape.escaped);
            end
        end
    end

    // Stall the receiver at the phase's rate
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // End the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [STEP_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_MAX_ITER:   cur_max_iter = data[DEF_ITER_WIDTH-1:0];
            CFG_ORIGIN_X:   cur_origin_x = data[ORIGIN_W-1:0];
            CFG_ORIGIN_Y:   cur_origin_y = data[ORIGIN_W-1:0];
            CFG_PIXEL_STEP: cur_step     = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold the pixel until it transfers, then queue what it should produce
    task automatic send_pixel(input logic [DEF_COORD_WIDTH-1:0] px,
                              input logic [DEF_COORD_WIDTH-1:0] py,
                              input bit typed, input t_escape_result want);
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            pix_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        pix_ch.valid   <= 1'b1;
        pix_ch.pixel_x <= px;
        pix_ch.pixel_y <= py;
        do @(posedge i_clk); while (!pix_ch.ready);
        predicted_escapes.push_back(typed ? want : escape_time(px, py));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (predicted_escapes.size() != 0) @(posedge i_clk);
    endtask

    // Pick a coordinate, mostly in a window around the origin that spans the set
    function automatic logic [DEF_COORD_WIDTH-1:0] pick_coord(input logic [ORIGIN_W-1:0] origin);
        longint w, v;
        if ($urandom_range(99) >= 60) return DEF_COORD_WIDTH'($urandom_range(1023));
        w = (cur_step == 0) ? 1023 : 590558003 / longint'(cur_step);
        if (w > 1023) w = 1023;
        v = longint'(origin) + longint'($urandom_range(32'(2 * w))) - w;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[DEF_COORD_WIDTH-1:0];
    endfunction

    function automatic t_stim_row cfg_row(input t_cfg_idx idx, input logic [STEP_W-1:0] data);
        t_stim_row r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        r.px     = '0;
        r.py     = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_stim_row pix_row(input int px, input int py, input bit typed,
                                          input int color, input int count, input bit esc);
        t_stim_row r;
        r.is_cfg       = 1'b0;
        r.idx          = CFG_MAX_ITER;
        r.data         = '0;
        r.px           = DEF_COORD_WIDTH'(px);
        r.py           = DEF_COORD_WIDTH'(py);
        r.typed        = typed;
        r.want.color   = COLOR_W'(color);
        r.want.count   = DEF_ITER_WIDTH'(count);
        r.want.escaped = esc;
        return r;
    endfunction

    initial begin
        logic [DEF_ITER_WIDTH-1:0] max_v;
        logic [ORIGIN_W-1:0]       ox, oy;
        logic [STEP_W-1:0]         step;
        int                        n;

        i_rst_n        = 1'b0;
        pix_ch.valid   = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_MAX_ITER;
        cfg_ch.data    = '0;
        cur_max_iter   = DEF_ITER_WIDTH'(RST_MAX_ITER);
        cur_origin_x   = ORIGIN_W'(RST_ORIGIN_X);
        cur_origin_y   = ORIGIN_W'(RST_ORIGIN_Y);
        cur_step       = STEP_W'(RST_PIXEL_STEP);

        // Reset defaults: center, corners, points inside and near the set
        directed.push_back(pix_row(160, 100, 1, 255, 100, 0));
        directed.push_back(pix_row(1023, 1023, 1, 2, 1, 1));
        directed.push_back(pix_row(0, 0, 0, 0, 0, 0));
        directed.push_back(pix_row(1023, 0, 0, 0, 0, 0));
        directed.push_back(pix_row(0, 1023, 0, 0, 0, 0));
        directed.push_back(pix_row(120, 100, 0, 0, 0, 0));
        directed.push_back(pix_row(170, 130, 0, 0, 0, 0));
        // Zero limit: nothing runs
        directed.push_back(cfg_row(CFG_MAX_ITER, STEP_W'(0)));
        directed.push_back(pix_row(160, 100, 1, 0, 0, 0));
        directed.push_back(pix_row(1023, 1023, 1, 0, 0, 0));
        // Limit reached before the step that would escape
        directed.push_back(cfg_row(CFG_MAX_ITER, STEP_W'(1)));
        directed.push_back(pix_row(1023, 1023, 1, 255, 1, 0));
        directed.push_back(pix_row(160, 100, 1, 255, 1, 0));
        // Zero step at the largest limit
        directed.push_back(cfg_row(CFG_MAX_ITER, STEP_W'(1023)));
        directed.push_back(cfg_row(CFG_PIXEL_STEP, STEP_W'(0)));
        directed.push_back(pix_row(5, 7, 1, 255, 1023, 0));
        directed.push_back(pix_row(1023, 1023, 1, 255, 1023, 0));
        // A step of one with origins at the extremes
        directed.push_back(cfg_row(CFG_PIXEL_STEP, STEP_W'(STEP_ONE)));
        directed.push_back(cfg_row(CFG_ORIGIN_X, STEP_W'(0)));
        directed.push_back(cfg_row(CFG_ORIGIN_Y, STEP_W'(1023)));
        directed.push_back(pix_row(0, 1023, 1, 255, 1023, 0));
        directed.push_back(pix_row(1, 1022, 0, 0, 0, 0));
        directed.push_back(pix_row(1023, 0, 0, 0, 0, 0));
        directed.push_back(pix_row(2, 1023, 0, 0, 0, 0));
        // Both coordinates saturate, one to each end of the range; then the origin pixel
        directed.push_back(cfg_row(CFG_ORIGIN_X, STEP_W'(1023)));
        directed.push_back(cfg_row(CFG_ORIGIN_Y, STEP_W'(0)));
        directed.push_back(pix_row(0, 1023, 0, 0, 0, 0));
        directed.push_back(pix_row(1023, 0, 0, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                wait_results_drained();
                write_reg(directed[k].idx, directed[k].data);
            end else begin
                send_pixel(directed[k].px, directed[k].py, directed[k].typed, directed[k].want);
            end
        end

        // Random phases, each with its own settings and idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_results_drained();
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 47; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 47; end
                default: begin send_idle = 10; recv_stall = 10; end
            endcase
            ox    = ORIGIN_W'($urandom_range(1023));
            oy    = ORIGIN_W'($urandom_range(1023));
            step  = STEP_W'($urandom_range(VIEW_HI, VIEW_LO));
            max_v = DEF_ITER_WIDTH'($urandom_range(64, 1));
            n     = PHASE_LEN;
            case (p)
                0: begin
                    max_v = DEF_ITER_WIDTH'(RST_MAX_ITER);
                    ox    = ORIGIN_W'(RST_ORIGIN_X);
                    oy    = ORIGIN_W'(RST_ORIGIN_Y);
                    step  = STEP_W'(RST_PIXEL_STEP);
                end
                1: begin max_v = DEF_ITER_WIDTH'(1); step = STEP_W'($urandom_range(STEP_ONE, 1)); end
                2: begin max_v = DEF_ITER_WIDTH'(1023); n = SLOW_LEN; end
                3: max_v = DEF_ITER_WIDTH'($urandom_range(16, 1));
                4: step = STEP_W'(STEP_ONE);
                5: begin step = STEP_W'(1); max_v = DEF_ITER_WIDTH'(8); end
                default: ;
            endcase
            write_reg(CFG_MAX_ITER, STEP_W'(max_v));
            write_reg(CFG_ORIGIN_X, STEP_W'(ox));
            write_reg(CFG_ORIGIN_Y, STEP_W'(oy));
            write_reg(CFG_PIXEL_STEP, step);
            repeat (n) send_pixel(pick_coord(cur_origin_x), pick_coord(cur_origin_y), 0, '0);
        end

        wait_results_drained();
        repeat (TAIL) @(posedge i_clk);
        if (mismatches == 0 && predicted_escapes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
